// ===== hdl/rpq_pkg.sv =====
`default_nettype none

package rpq_pkg;

  // Width of the data word and of one GF(2^8) symbol.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NBYTES  = WORD_W / BYTE_W;

  // Disk counter and configuration port widths.
  localparam int unsigned DISK_W  = 6;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned CADDR_W = 2;
  localparam int unsigned CDATA_W = 8;

  // Register indexes on the configuration port.
  localparam logic [CADDR_W-1:0] CFG_DATA_DISKS   = 2'd0;
  localparam logic [CADDR_W-1:0] CFG_PARITY_LEVEL = 2'd1;

  // Reset values of the registers and the level that gives P only.
  localparam logic [DISK_W-1:0]  DISKS_RESET   = 6'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_P_ONLY  = 2'd1;

  // Low byte of the field polynomial 0x11d.
  localparam logic [BYTE_W-1:0]  GF_POLY_LOW   = 8'h1d;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              last_column;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] p_word;
    logic [WORD_W-1:0] q_word;
    logic              run_end;
  } out_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              first;
    logic              done;
    logic              last_column;
    logic              q_zero;
  } op_t;

  // Multiply every byte by 2 in GF(2^8) modulo 0x11d, no carry across bytes.
  function automatic logic [WORD_W-1:0] gf_double(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    logic [BYTE_W-1:0] b;
    r = '0;
    for (int i = 0; i < NBYTES; i++) begin
      b = v[i*BYTE_W +: BYTE_W];
      r[i*BYTE_W +: BYTE_W] = {b[BYTE_W-2:0], 1'b0} ^ (b[BYTE_W-1] ? GF_POLY_LOW : '0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rpq_front.sv =====
`default_nettype none

module rpq_front #(
  parameter int unsigned LANE_BYTES = 8,
  parameter int unsigned MAX_DISKS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rpq_pkg::CADDR_W-1:0] cfg_addr,
  input  wire logic [rpq_pkg::CDATA_W-1:0] cfg_wdata,
  input  wire logic                        in_push,
  input  wire rpq_pkg::in_t                in_data,
  input  wire logic                        q_full,
  output logic                             op_push,
  output rpq_pkg::op_t                     op
);
  import rpq_pkg::*;

  // Effective lane count and disk clamp, settled at elaboration.
  localparam int unsigned LB       = (LANE_BYTES > NBYTES) ? NBYTES : LANE_BYTES;
  localparam int unsigned DISK_MAX = (1 << DISK_W) - 1;
  localparam int unsigned CLAMP    = (MAX_DISKS > DISK_MAX) ? DISK_MAX :
                                     ((MAX_DISKS < 1) ? 1 : MAX_DISKS);
  localparam logic [DISK_W-1:0] CLAMP_V = DISK_W'(CLAMP);
  localparam logic [WORD_W-1:0] LANE_MASK = (LB >= NBYTES) ? {WORD_W{1'b1}} :
                                  ((WORD_W'(1) << (BYTE_W * LB)) - WORD_W'(1));

  logic [DISK_W-1:0]  data_disks_r, data_disks_nxt;
  logic [LEVEL_W-1:0] parity_level_r, parity_level_nxt;
  logic [DISK_W-1:0]  disk_idx_r, disk_idx_nxt;
  logic [DISK_W-1:0]  disk_cnt;
  logic [DISK_W:0]    idx_inc;
  logic               col_done;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;

  // Configuration registers.
  always_comb begin
    data_disks_nxt   = data_disks_r;
    parity_level_nxt = parity_level_r;
    if (cfg_valid) begin
      if (cfg_addr == CFG_DATA_DISKS) begin
        data_disks_nxt = cfg_wdata[DISK_W-1:0];
      end else if (cfg_addr == CFG_PARITY_LEVEL) begin
        parity_level_nxt = cfg_wdata[LEVEL_W-1:0];
      end
    end
  end

  // Column length: zero disks count as one, and the count is clamped.
  always_comb begin
    disk_cnt = (data_disks_r == '0) ? DISK_W'(1) : data_disks_r;
    if (disk_cnt > CLAMP_V) begin
      disk_cnt = CLAMP_V;
    end
  end

  // The column ends once the words seen reach the disk count.
  assign idx_inc  = {1'b0, disk_idx_r} + (DISK_W+1)'(1);
  assign col_done = idx_inc >= {1'b0, disk_cnt};

  always_comb begin
    disk_idx_nxt = disk_idx_r;
    if (accept) begin
      disk_idx_nxt = col_done ? '0 : idx_inc[DISK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_disks_r   <= DISKS_RESET;
      parity_level_r <= LEVEL_RESET;
      disk_idx_r     <= '0;
    end else begin
      data_disks_r   <= data_disks_nxt;
      parity_level_r <= parity_level_nxt;
      disk_idx_r     <= disk_idx_nxt;
    end
  end

  // Classified request handed to the queue.
  assign op_push        = accept;
  assign op.data        = in_data.data_word & LANE_MASK;
  assign op.first       = (disk_idx_r == '0);
  assign op.done        = col_done;
  assign op.last_column = in_data.last_column;
  assign op.q_zero      = (parity_level_r == LEVEL_P_ONLY);

endmodule

`default_nettype wire

// ===== hdl/rpq_op_queue.sv =====
`default_nettype none

module rpq_op_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire rpq_pkg::op_t push_op,
  output logic              full,
  output logic              valid,
  input  wire logic         pop,
  output rpq_pkg::op_t      head
);
  import rpq_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rpq_back.sv =====
`default_nettype none

module rpq_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         op_valid,
  input  wire rpq_pkg::op_t op,
  output logic              op_pop,
  output logic              out_empty,
  input  wire logic         out_pop,
  output rpq_pkg::out_t     out_data
);
  import rpq_pkg::*;

  logic [WORD_W-1:0] p_r, p_nxt;
  logic [WORD_W-1:0] q_r, q_nxt;
  out_t              res_r [2];
  out_t              res_new;
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              res_full;
  logic              res_wr;
  logic              res_rd;

  assign res_full  = (count_r == 2'd2);
  assign out_empty = (count_r == 2'd0);
  assign out_data  = res_r[rd_ptr_r];

  // A word that ends a column waits for room in the result queue.
  assign op_pop = op_valid && (!op.done || !res_full);
  assign res_wr = op_pop && op.done;
  assign res_rd = out_pop && !out_empty;

  // Parity accumulation: P by XOR, Q by Horner's rule.
  always_comb begin
    if (op.first) begin
      p_nxt = op.data;
      q_nxt = op.data;
    end else begin
      p_nxt = p_r ^ op.data;
      q_nxt = gf_double(q_r) ^ op.data;
    end
  end

  always_comb begin
    res_new.p_word  = p_nxt;
    res_new.q_word  = op.q_zero ? '0 : q_nxt;
    res_new.run_end = op.last_column;
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  // Result queue control.
  always_comb begin
    wr_ptr_nxt = res_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = res_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(res_wr) - 2'(res_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_r[wr_ptr_r] <= res_new;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/raid6_pq_syndrome_gen.sv =====
// RAID-6 P/Q syndrome generator over GF(2^8) with polynomial 0x11d. Feed one
// 64-bit word per disk, column by column, each column from the highest data
// disk down to disk 0; a result holding P, Q and the run mark of the final
// word appears once disk 0 of a column has gone in. The block takes one word
// every clock while the result side keeps popping: a front stage counts disks
// and classifies words, a two-entry request queue feeds the back stage that
// does the XOR and GF doubling, and a two-entry result queue holds finished
// columns. A result shows once the back stage pops the word ending its column
// from the request queue and writes the result queue. Input stalls only when
// both queues are full. The user must write registers 0 (data_disks) and 1
// (parity_level, 1 for P only) only while idle; the block does not enforce it.
`default_nettype none

module raid6_pq_syndrome_gen #(
  parameter int unsigned LANE_BYTES = 8,
  parameter int unsigned MAX_DISKS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rpq_pkg::CADDR_W-1:0] cfg_addr,
  input  wire logic [rpq_pkg::CDATA_W-1:0] cfg_wdata,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire rpq_pkg::in_t                in_data,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output rpq_pkg::out_t                    out_data
);
  import rpq_pkg::*;

  logic op_push;
  op_t  op_in;
  logic q_full;
  logic q_valid;
  logic q_pop;
  op_t  q_head;

  assign in_full = q_full;

  // Front: configuration, disk counting and classification.
  rpq_front #(
    .LANE_BYTES (LANE_BYTES),
    .MAX_DISKS  (MAX_DISKS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .q_full    (q_full),
    .op_push   (op_push),
    .op        (op_in)
  );

  // Queue between the two halves.
  rpq_op_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (op_in),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .head    (q_head)
  );

  // Back: accumulation and result queue.
  rpq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (q_head),
    .op_pop    (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/rpq_checker.sv =====
`default_nettype none

module rpq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_push,
  input wire logic                        in_full,
  input wire logic                        out_empty,
  input wire logic                        out_pop,
  input wire rpq_pkg::out_t               out_data
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result holds until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result changed before it was popped");

  // The input side only fills up through accepted requests.
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input went full without a push");

  // A result needs a word and a pass through the back stage after reset.
  a_result_latency: assert property (@(posedge clk)
    $fell(out_empty) |-> $past(rst_n, 1) && $past(rst_n, 2))
    else $error("result appeared too soon after reset");

endmodule

bind raid6_pq_syndrome_gen rpq_checker u_rpq_checker (.*);

`default_nettype wire
